>>> hw/rtl/ipv4et_pkg.sv
// Shared types and constants for the IPv4 echo turnaround rewriter.
package ipv4et_pkg;

	localparam int unsigned LEN_W    = 6;
	localparam int unsigned SUM_W    = 22;
	localparam int unsigned QDEPTH   = 4;
	localparam int unsigned QPTR_W   = 2;
	localparam int unsigned QCNT_W   = 3;

	localparam logic [LEN_W-1:0] HDR_MIN    = 6'd20;
	localparam logic [LEN_W-1:0] K_CHK_HI   = 6'd10;
	localparam logic [LEN_W-1:0] K_CHK_LO   = 6'd11;
	localparam logic [LEN_W-1:0] K_SRC_LO   = 6'd12;
	localparam logic [LEN_W-1:0] K_DST_LO   = 6'd16;
	localparam logic [LEN_W-1:0] K_DST_END  = 6'd20;
	localparam logic [LEN_W-1:0] ADDR_SWAP  = 6'd4;
	localparam logic [15:0]      SUM16_MASK = 16'hffff;

	typedef enum logic [1:0] {
		CMD_PASS  = 2'd0,
		CMD_BURST = 2'd1,
		CMD_FLUSH = 2'd2
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t         kind;
		logic [7:0]        data;
		logic              last;
		logic [LEN_W-1:0]  len;
		logic [SUM_W-1:0]  sum;
	} cmd_t;

endpackage

>>> hw/rtl/ipv4_echo_turnaround_rewriter.sv
// Top level: IPv4 echo turnaround rewriter, byte stream in and out.
// Past the header: command queue, then output register; one byte per cycle unless held up.
// A header of N bytes is replayed from the header RAM one byte at a time (read, then send);
// new header bytes wait until the replay ends.
// Command queue holds 4 entries between the input and output sides.
// arst_n clears position, header length (20), running sum, queue and output valid.
module ipv4_echo_turnaround_rewriter
	import ipv4et_pkg::*;
#(
	parameter int unsigned HEADER_BYTES_MAX = 60,
	parameter int unsigned PACKET_BYTES_MAX = 4096
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,  // [7:0] data_byte
	input  logic       s_tlast,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,  // [7:0] out_byte
	output logic       m_tlast
);

	localparam int unsigned AW = $clog2(HEADER_BYTES_MAX);

	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [7:0]    ram_wdata;
	logic [AW-1:0] ram_raddr;
	logic [7:0]    ram_rdata;
	logic          q_push;
	cmd_t          q_cmd;
	logic          q_full;
	logic          q_pop;
	logic          q_empty;
	cmd_t          q_head;
	logic          burst_done;

	ipv4et_front #(
		.HEADER_BYTES_MAX(HEADER_BYTES_MAX),
		.PACKET_BYTES_MAX(PACKET_BYTES_MAX)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_byte    (s_tdata),
		.in_last    (s_tlast),
		.ram_we     (ram_we),
		.ram_waddr  (ram_waddr),
		.ram_wdata  (ram_wdata),
		.q_push     (q_push),
		.q_cmd      (q_cmd),
		.q_full     (q_full),
		.burst_done (burst_done)
	);

	ipv4et_ram #(
		.WIDTH(8),
		.DEPTH(HEADER_BYTES_MAX)
	) u_hdr_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	ipv4et_cmdq u_cmdq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (q_cmd),
		.full     (q_full),
		.pop      (q_pop),
		.empty    (q_empty),
		.head     (q_head)
	);

	ipv4et_back #(
		.HEADER_BYTES_MAX(HEADER_BYTES_MAX)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.q_head     (q_head),
		.q_pop      (q_pop),
		.ram_raddr  (ram_raddr),
		.ram_rdata  (ram_rdata),
		.burst_done (burst_done),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_byte   (m_tdata),
		.out_last   (m_tlast)
	);

endmodule

>>> hw/rtl/ipv4et_ram.sv
// Generic single-port-write, registered-read RAM.
module ipv4et_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 60
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> hw/rtl/ipv4et_cmdq.sv
// Short command queue between the front and back parts.
module ipv4et_cmdq
	import ipv4et_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output logic empty,
	output cmd_t head
);

	cmd_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign full    = (count_q == QCNT_W'(QDEPTH));
	assign empty   = (count_q == '0);
	assign head    = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + QCNT_W'(1);
				2'b01:   count_q <= count_q - QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> hw/rtl/ipv4et_front.sv
// Input side: tracks packet position, stores the header, sums it, queues commands.
module ipv4et_front
	import ipv4et_pkg::*;
#(
	parameter int unsigned HEADER_BYTES_MAX = 60,
	parameter int unsigned PACKET_BYTES_MAX = 4096
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [7:0]                          in_byte,
	input  logic                                in_last,
	output logic                                ram_we,
	output logic [$clog2(HEADER_BYTES_MAX)-1:0] ram_waddr,
	output logic [7:0]                          ram_wdata,
	output logic                                q_push,
	output cmd_t                                q_cmd,
	input  logic                                q_full,
	input  logic                                burst_done
);

	localparam int unsigned IDX_W = $clog2(PACKET_BYTES_MAX + 1);
	localparam int unsigned AW    = $clog2(HEADER_BYTES_MAX);
	localparam logic [LEN_W-1:0] HMAX = LEN_W'(HEADER_BYTES_MAX);
	localparam logic [IDX_W-1:0] IDX_SAT = IDX_W'(PACKET_BYTES_MAX);

	logic [IDX_W-1:0] idx_q;
	logic [LEN_W-1:0] hlen_q;
	logic [SUM_W-1:0] sum_q;
	logic             hold_q;

	logic             in_hdr;
	logic             accept;
	logic [LEN_W-1:0] ihl4;
	logic [LEN_W-1:0] hl_eff;
	logic [IDX_W-1:0] idx_inc;
	logic [SUM_W-1:0] word;
	logic [SUM_W-1:0] sum_nxt;
	logic             hdr_end;
	logic             counted;

	assign in_hdr   = idx_q < IDX_W'(hlen_q);
	assign in_ready = !q_full && !(in_hdr && hold_q);
	assign accept   = in_valid && in_ready;
	assign idx_inc  = idx_q + IDX_W'(1);

	always_comb begin
		ihl4 = {in_byte[3:0], 2'b00};
		if (idx_q != '0) begin
			hl_eff = hlen_q;
		end else if (ihl4 < HDR_MIN) begin
			hl_eff = HDR_MIN;
		end else if (ihl4 > HMAX) begin
			hl_eff = HMAX;
		end else begin
			hl_eff = ihl4;
		end
	end

	// Checksum field counts as zero.
	assign counted = (idx_q != IDX_W'(K_CHK_HI)) && (idx_q != IDX_W'(K_CHK_LO));
	assign word    = idx_q[0] ? SUM_W'(in_byte) : SUM_W'({in_byte, 8'h00});
	assign sum_nxt = counted ? (sum_q + word) : sum_q;
	assign hdr_end = (idx_inc == IDX_W'(hl_eff));

	assign ram_we    = accept && in_hdr;
	assign ram_waddr = AW'(idx_q);
	assign ram_wdata = in_byte;

	always_comb begin
		q_push      = 1'b0;
		q_cmd.kind  = CMD_PASS;
		q_cmd.data  = in_byte;
		q_cmd.last  = in_last;
		q_cmd.len   = hl_eff;
		q_cmd.sum   = sum_nxt;
		if (in_hdr) begin
			if (hdr_end) begin
				q_push     = accept;
				q_cmd.kind = CMD_BURST;
			end else if (in_last) begin
				q_push     = accept;
				q_cmd.kind = CMD_FLUSH;
				q_cmd.len  = LEN_W'(idx_inc);
			end
		end else begin
			q_push = accept;
			// ICMP type byte goes out as zero.
			if (idx_q == IDX_W'(hlen_q)) begin
				q_cmd.data = 8'h00;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= '0;
			hlen_q <= HDR_MIN;
			sum_q  <= '0;
			hold_q <= 1'b0;
		end else begin
			if (q_push && q_cmd.kind != CMD_PASS) begin
				hold_q <= 1'b1;
			end else if (burst_done) begin
				hold_q <= 1'b0;
			end
			if (accept) begin
				if (in_last) begin
					idx_q  <= '0;
					hlen_q <= HDR_MIN;
					sum_q  <= '0;
				end else begin
					if (idx_q < IDX_SAT) begin
						idx_q <= idx_inc;
					end
					if (in_hdr) begin
						hlen_q <= hl_eff;
						sum_q  <= sum_nxt;
					end
				end
			end
		end
	end

endmodule

>>> hw/rtl/ipv4et_back.sv
// Output side: executes queued commands, replays headers from the store.
module ipv4et_back
	import ipv4et_pkg::*;
#(
	parameter int unsigned HEADER_BYTES_MAX = 60
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                q_empty,
	input  cmd_t                                q_head,
	output logic                                q_pop,
	output logic [$clog2(HEADER_BYTES_MAX)-1:0] ram_raddr,
	input  logic [7:0]                          ram_rdata,
	output logic                                burst_done,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [7:0]                          out_byte,
	output logic                                out_last
);

	localparam int unsigned AW = $clog2(HEADER_BYTES_MAX);

	typedef enum logic [2:0] {
		B_IDLE = 3'b001,
		B_READ = 3'b010,
		B_SEND = 3'b100
	} bstate_t;

	bstate_t          state_q;
	logic [LEN_W-1:0] k_q;
	logic [LEN_W-1:0] len_q;
	logic             last_q;
	logic             swap_q;
	logic [15:0]      chk_q;
	logic             out_valid_q;
	logic [7:0]       out_byte_q;
	logic             out_last_q;

	logic             out_free;
	logic [LEN_W-1:0] src_k;
	logic             k_final;
	logic [7:0]       send_byte;
	logic [16:0]      fold1;
	logic [15:0]      fold2;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign out_last  = out_last_q;

	// Swap source and destination address bytes.
	always_comb begin
		if (swap_q && k_q >= K_SRC_LO && k_q < K_DST_LO) begin
			src_k = k_q + ADDR_SWAP;
		end else if (swap_q && k_q >= K_DST_LO && k_q < K_DST_END) begin
			src_k = k_q - ADDR_SWAP;
		end else begin
			src_k = k_q;
		end
	end
	assign ram_raddr = AW'(src_k);

	assign fold1 = 17'(q_head.sum[SUM_W-1:16]) + 17'(q_head.sum[15:0]);
	assign fold2 = fold1[15:0] + 16'(fold1[16]);

	assign k_final = (k_q == len_q - LEN_W'(1));

	always_comb begin
		if (swap_q && k_q == K_CHK_HI) begin
			send_byte = chk_q[15:8];
		end else if (swap_q && k_q == K_CHK_LO) begin
			send_byte = chk_q[7:0];
		end else begin
			send_byte = ram_rdata;
		end
	end

	always_comb begin
		q_pop = 1'b0;
		if (state_q == B_IDLE && !q_empty) begin
			q_pop = (q_head.kind == CMD_PASS) ? out_free : 1'b1;
		end
	end

	assign burst_done = (state_q == B_SEND) && out_free && k_final;

	always_ff @(posedge clk) begin
		if (state_q == B_IDLE && q_pop && q_head.kind != CMD_PASS) begin
			len_q  <= q_head.len;
			last_q <= q_head.last || (q_head.kind == CMD_FLUSH);
			swap_q <= (q_head.kind == CMD_BURST);
			chk_q  <= ~fold2 & SUM16_MASK;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (state_q == B_IDLE) begin
				out_byte_q <= q_head.data;
				out_last_q <= q_head.last;
			end else begin
				out_byte_q <= send_byte;
				out_last_q <= k_final && last_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				B_IDLE: begin
					if (q_pop && q_head.kind == CMD_PASS) begin
						out_valid_q <= 1'b1;
					end else begin
						if (out_ready) begin
							out_valid_q <= 1'b0;
						end
						if (q_pop) begin
							k_q     <= '0;
							state_q <= B_READ;
						end
					end
				end
				B_READ: begin
					if (out_ready) begin
						out_valid_q <= 1'b0;
					end
					state_q <= B_SEND;
				end
				B_SEND: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						if (k_final) begin
							state_q <= B_IDLE;
						end else begin
							k_q     <= k_q + LEN_W'(1);
							state_q <= B_READ;
						end
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

endmodule

>>> tb/testbench.sv
// Testbench for the IPv4 echo turnaround rewriter: directed and random packets, checked byte by byte.
module testbench;
	import ipv4et_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int HEADER_BYTES_MAX = 60;
	localparam int PACKET_BYTES_MAX = 64;
	localparam int CYCLE_LIMIT      = 400000;
	localparam int DRAIN_CYCLES     = 200;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} out_beat_t;

	logic       clk      = 1'b0;
	logic       arst_n   = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata  = 8'h00;
	logic       s_tlast  = 1'b0;
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;
	logic       m_tlast;

	// predictor state
	logic [7:0]  held_header [HEADER_BYTES_MAX];
	int          pos       = 0;
	int          hdr_len   = HDR_MIN;
	logic [21:0] run_sum   = '0;
	out_beat_t   expected_bytes[$];

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int error_count    = 0;
	int out_count      = 0;
	int cycle_count    = 0;
	out_beat_t want;

	ipv4_echo_turnaround_rewriter #(
		.HEADER_BYTES_MAX(HEADER_BYTES_MAX),
		.PACKET_BYTES_MAX(PACKET_BYTES_MAX)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tlast (s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("[ipv4_echo_turnaround_rewriter] ERROR");
			$finish;
		end
	end

	task automatic report_mismatch(input string what);
		$display("mismatch: %s", what);
		error_count++;
	endtask

	// Compute the rewritten bytes caused by one accepted input byte.
	task automatic rewrite_byte(input logic [7:0] d, input logic l);
		int          hl;
		int          src;
		int          k;
		logic [31:0] folded;
		logic [15:0] chk;
		out_beat_t   beat;
		if (pos < hdr_len) begin
			if (pos == 0) begin
				hl = int'(d[3:0]) * 4;
				if (hl < HDR_MIN) hl = HDR_MIN;
				if (hl > HEADER_BYTES_MAX) hl = HEADER_BYTES_MAX;
				hdr_len = hl;
			end
			held_header[pos] = d;
			if (pos != K_CHK_HI && pos != K_CHK_LO)
				run_sum = run_sum + (pos[0] ? 22'(d) : 22'({d, 8'h00}));
			if (pos + 1 == hdr_len) begin
				folded = 32'(run_sum);
				folded = (folded >> 16) + (folded & SUM16_MASK);
				folded = folded + (folded >> 16);
				chk = ~folded[15:0];
				for (k = 0; k < hdr_len; k++) begin
					src = k;
					if (k >= K_SRC_LO && k < K_DST_LO) src = k + ADDR_SWAP;
					else if (k >= K_DST_LO && k < K_DST_END) src = k - ADDR_SWAP;
					if (k == K_CHK_HI) beat.data = chk[15:8];
					else if (k == K_CHK_LO) beat.data = chk[7:0];
					else beat.data = held_header[src];
					beat.last = (k == hdr_len - 1) ? l : 1'b0;
					expected_bytes.push_back(beat);
				end
			end else if (l) begin
				// short packet: flush what was held, unchanged
				for (k = 0; k <= pos; k++) begin
					beat.data = held_header[k];
					beat.last = (k == pos);
					expected_bytes.push_back(beat);
				end
			end
		end else begin
			beat.data = (pos == hdr_len) ? 8'h00 : d;
			beat.last = l;
			expected_bytes.push_back(beat);
		end
		if (l) begin
			pos = 0;
			hdr_len = HDR_MIN;
			run_sum = '0;
		end else if (pos < PACKET_BYTES_MAX) begin
			pos++;
		end
	endtask

	// Drive one byte; returns right after the edge at which it transfers.
	task automatic send_byte(input logic [7:0] d, input logic l);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= d;
		s_tlast  <= l;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		rewrite_byte(d, l);
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_bytes.size() == 0) begin
				report_mismatch($sformatf("output %0d: unexpected byte %02h last %0b",
					out_count, m_tdata, m_tlast));
			end else begin
				want = expected_bytes.pop_front();
				if (m_tdata !== want.data)
					report_mismatch($sformatf("output %0d: byte %02h, want %02h",
						out_count, m_tdata, want.data));
				if (m_tlast !== want.last)
					report_mismatch($sformatf("output %0d: last %0b, want %0b",
						out_count, m_tlast, want.last));
			end
			out_count++;
		end
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// One-byte packet, then a small-IHL header with ICMP type and payload.
	task automatic test_directed();
		int i;
		send_byte(8'hff, 1'b1);
		send_byte(8'h42, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hff, 1'b0);
		for (i = 3; i < 20; i++)
			send_byte(i[0] ? 8'hff : 8'(i * 13), 1'b0);
		send_byte(8'h08, 1'b0);
		send_byte(8'ha5, 1'b1);
	endtask

	task automatic test_random_packets(input int n_items);
		int         sent;
		int         i;
		int         hlen;
		int         total;
		int         pick;
		logic [7:0] first;
		sent = 0;
		while (sent < n_items) begin
			first = 8'($urandom);
			if ($urandom_range(99) < 75) first[7:4] = 4'h4;
			pick = $urandom_range(99);
			if (pick < 60) first[3:0] = 4'($urandom_range(5, 7));
			else if (pick < 75) first[3:0] = 4'hf;
			else if (pick < 85) first[3:0] = 4'($urandom_range(0, 4));
			else first[3:0] = 4'($urandom);
			hlen = int'(first[3:0]) * 4;
			if (hlen < HDR_MIN) hlen = HDR_MIN;
			pick = $urandom_range(99);
			if (pick < 15) total = $urandom_range(1, hlen - 1);
			else if (pick < 30) total = hlen;
			else total = hlen + $urandom_range(1, 8);
			for (i = 0; i < total; i++)
				send_byte((i == 0) ? first : 8'($urandom), i == total - 1);
			sent += total;
		end
	endtask

	// Run past the position limit; bytes must keep passing through.
	task automatic test_long_packet();
		int i;
		int total;
		total = PACKET_BYTES_MAX + 8;
		for (i = 0; i < total; i++)
			send_byte((i == 0) ? 8'h45 : 8'($urandom), i == total - 1);
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 0;
		recv_stall_pct = 0;
		test_directed();
		test_random_packets(8);

		send_idle_pct = 67;
		recv_stall_pct = 0;
		test_random_packets(8);

		send_idle_pct = 0;
		recv_stall_pct = 67;
		test_random_packets(8);

		send_idle_pct = 35;
		recv_stall_pct = 35;
		test_long_packet();

		s_tvalid <= 1'b0;
		while (expected_bytes.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (error_count == 0) begin
			$display("[ipv4_echo_turnaround_rewriter] OK");
		end else begin
			$display("[ipv4_echo_turnaround_rewriter] ERROR");
		end
		$finish;
	end

endmodule

>>> filelist.f
hw/rtl/ipv4et_pkg.sv
hw/rtl/ipv4et_ram.sv
hw/rtl/ipv4et_cmdq.sv
hw/rtl/ipv4et_front.sv
hw/rtl/ipv4et_back.sv
hw/rtl/ipv4_echo_turnaround_rewriter.sv
tb/testbench.sv
